### rtl/core/dmx_pkg.sv
// ----------------------------------------------------------------------------
// dmx_pkg: shared types and constants
// Beat formats, register indexes and the per-frame reciprocal table for the
// down-mixing resampler.
// ----------------------------------------------------------------------------
`default_nettype none
package dmx_pkg;

  localparam int SampleBits    = 24;
  localparam int PhaseFracBits = 16;
  localparam int PhaseBits     = 21;
  localparam int SumBits       = 27;
  localparam int MaxChannels   = 8;
  localparam int ResultCap     = 32;

  localparam logic [1:0] FMT_PCM16 = 2'd0;
  localparam logic [1:0] FMT_PCM32 = 2'd1;
  localparam logic [1:0] FMT_FLT32 = 2'd2;

  localparam logic [1:0] REG_FORMAT   = 2'd0;
  localparam logic [1:0] REG_CHANNELS = 2'd1;
  localparam logic [1:0] REG_STEP     = 2'd2;

  localparam logic signed [SampleBits-1:0] SMP_MAX = {1'b0, {(SampleBits-1){1'b1}}};
  localparam logic signed [SampleBits-1:0] SMP_MIN = {1'b1, {(SampleBits-1){1'b0}}};

  localparam logic [PhaseBits-1:0] PHASE_ONE  = PhaseBits'(1) << PhaseFracBits;
  localparam logic [19:0]          STEP_MIN   = 20'(1 << (PhaseFracBits - 4));
  localparam logic [19:0]          STEP_MAX   = 20'(12 << PhaseFracBits);

  typedef struct packed {
    logic [31:0] sample_word;
    logic        end_of_stream;
  } in_beat_t;

  typedef struct packed {
    logic signed [SampleBits-1:0] mono_sample;
    logic                         run_last;
    logic                         stream_last;
  } out_beat_t;

  // One classified item handed from the front to the back.
  typedef struct packed {
    logic                         frame_done;
    logic                         eos;
    logic signed [SampleBits-1:0] cur;
  } job_t;

  // Reciprocal in Q1.16, round(65536/count).
  function automatic logic [16:0] recip_of(input logic [3:0] c);
    logic [16:0] r;
    unique case (c)
      4'd1:    r = 17'd65536;
      4'd2:    r = 17'd32768;
      4'd3:    r = 17'd21845;
      4'd4:    r = 17'd16384;
      4'd5:    r = 17'd13107;
      4'd6:    r = 17'd10923;
      4'd7:    r = 17'd9362;
      default: r = 17'd8192;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/core/dmx_front.sv
// ----------------------------------------------------------------------------
// dmx_front: decode and frame averaging
// Decodes each word, sums a frame, scales by the reciprocal and hands jobs on.
// ----------------------------------------------------------------------------
`default_nettype none
module dmx_front import dmx_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_push,
  output logic            in_full,
  input  wire in_beat_t   in_data,
  input  wire logic [1:0] sample_format,
  input  wire logic [3:0] channel_count,
  input  wire logic       q_full,
  output logic            q_push,
  output job_t            q_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_PUSH = 2'd2;

  logic [1:0]                st_r, st_nxt;
  logic [2:0]                chan_idx_r, chan_idx_nxt;
  logic signed [SumBits-1:0] sum_r, sum_nxt;
  logic signed [SumBits-1:0] msum_r;
  logic signed [44:0]        prod_r;
  logic                      eos_r;
  logic [3:0]                chans;
  logic signed [SampleBits-1:0] dec;
  logic signed [SumBits-1:0] add_sum;
  logic                      accept, complete;
  logic signed [28:0]        scaled;
  logic signed [SampleBits-1:0] cur;
  logic [7:0]                fexp;
  logic [23:0]               mant, mag;
  logic [7:0]                rsh;

  assign chans = (channel_count == 4'd0) ? 4'd1 :
                 (channel_count > 4'(MaxChannels)) ? 4'(MaxChannels) : channel_count;

  always_comb begin
    fexp = in_data.sample_word[30:23];
    mant = {1'b1, in_data.sample_word[22:0]};
    rsh  = 8'd127 - fexp;
    mag  = (rsh >= 8'd24) ? 24'd0 : (mant >> rsh[4:0]);
    dec  = '0;
    unique case (sample_format)
      FMT_PCM16: dec = {in_data.sample_word[15:0], 8'd0};
      FMT_PCM32: dec = in_data.sample_word[31:8];
      FMT_FLT32: begin
        if (fexp == 8'hFF) begin
          if (in_data.sample_word[22:0] != 23'd0) dec = '0;
          else dec = in_data.sample_word[31] ? SMP_MIN : SMP_MAX;
        end else if (fexp == 8'd0) begin
          dec = '0;
        end else if (fexp >= 8'd127) begin
          dec = in_data.sample_word[31] ? SMP_MIN : SMP_MAX;
        end else begin
          dec = in_data.sample_word[31] ? -$signed(mag) : $signed(mag);
        end
      end
      default:   dec = '0;
    endcase
  end

  assign in_full  = (st_r != ST_IDLE) || q_full;
  assign accept   = in_push && !in_full;
  assign add_sum  = sum_r + SumBits'(dec);
  assign complete = ({1'b0, chan_idx_r} + 4'd1) >= chans;

  assign scaled = prod_r[44:16];
  assign cur = (scaled > 29'(SMP_MAX)) ? SMP_MAX :
               (scaled < 29'(SMP_MIN)) ? SMP_MIN : scaled[SampleBits-1:0];

  always_comb begin
    st_nxt       = st_r;
    chan_idx_nxt = chan_idx_r;
    sum_nxt      = sum_r;
    q_push       = 1'b0;
    q_data       = '{frame_done: 1'b1, eos: eos_r, cur: cur};
    unique case (st_r)
      ST_IDLE: begin
        if (accept) begin
          if (complete) begin
            chan_idx_nxt = '0;
            sum_nxt      = '0;
            st_nxt       = ST_MUL;
          end else if (in_data.end_of_stream) begin
            // A partial frame is dropped; only the tail is asked for.
            chan_idx_nxt = '0;
            sum_nxt      = '0;
            q_push       = 1'b1;
            q_data       = '{frame_done: 1'b0, eos: 1'b1, cur: '0};
          end else begin
            chan_idx_nxt = chan_idx_r + 3'd1;
            sum_nxt      = add_sum;
          end
        end
      end
      ST_MUL:  st_nxt = ST_PUSH;
      ST_PUSH: begin
        if (!q_full) begin
          q_push = 1'b1;
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= ST_IDLE;
      chan_idx_r <= '0;
      sum_r      <= '0;
    end else begin
      st_r       <= st_nxt;
      chan_idx_r <= chan_idx_nxt;
      sum_r      <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      msum_r <= add_sum;
      eos_r  <= in_data.end_of_stream;
    end
    prod_r <= 45'(msum_r) * $signed({1'b0, recip_of(chans)});
  end

endmodule
`default_nettype wire

### rtl/core/dmx_jobq.sv
// ----------------------------------------------------------------------------
// dmx_jobq: job queue
// Two-entry queue of classified jobs between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none
module dmx_jobq import dmx_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t push_data,
  output logic      full,
  input  wire logic pop,
  output logic      empty,
  output job_t      pop_data
);

  job_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       do_push, do_pop;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= ~wp_r;
      if (do_pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= push_data;
  end

endmodule
`default_nettype wire

### rtl/core/dmx_back.sv
// ----------------------------------------------------------------------------
// dmx_back: interpolation sequencer
// Walks the output phase across each sample interval and the end-of-stream
// tail, one result per cycle while the result queue has room, into a two-entry result queue.
// ----------------------------------------------------------------------------
`default_nettype none
module dmx_back import dmx_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [19:0] phase_step,
  input  wire logic        q_empty,
  input  wire job_t        q_data,
  output logic             q_pop,
  output logic             out_empty,
  input  wire logic        out_pop,
  output out_beat_t        out_data
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_INTERP = 2'd1;
  localparam logic [1:0] ST_TAIL   = 2'd2;

  logic [1:0]                   st_r, st_nxt;
  logic signed [SampleBits-1:0] prev_r, prev_nxt, cur_r, cur_nxt;
  logic                         hp_r, hp_nxt, eos_r, eos_nxt;
  logic [PhaseBits-1:0]         ph_r, ph_nxt;
  logic [5:0]                   n_r, n_nxt;

  out_beat_t  rq_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       wr, rd, space;
  out_beat_t  wr_data;

  logic [19:0]                  step;
  logic signed [SampleBits:0]   diff;
  logic signed [41:0]           prod;
  logic signed [SampleBits-1:0] y;
  logic [PhaseBits-1:0]         ph2, ph_adj;
  logic [5:0]                   n2;
  logic                         more, tail_go;
  logic                         hp_a;
  logic signed [SampleBits-1:0] prev_a;
  logic [PhaseBits-1:0]         ph_a;

  assign step  = (phase_step < STEP_MIN) ? STEP_MIN :
                 (phase_step > STEP_MAX) ? STEP_MAX : phase_step;
  assign diff  = {cur_r[SampleBits-1], cur_r} - {prev_r[SampleBits-1], prev_r};
  assign prod  = 42'(diff) * $signed({1'b0, ph_r[PhaseFracBits-1:0]});
  assign y     = prev_r + prod[PhaseFracBits+SampleBits-1:PhaseFracBits];
  assign ph2   = ph_r + PhaseBits'(step);
  assign n2    = n_r + 6'd1;
  assign more  = (ph2 < PHASE_ONE) && (n2 < 6'(ResultCap));
  assign ph_adj = (ph2 >= PHASE_ONE) ? ph2 - PHASE_ONE : '0;
  assign tail_go = eos_r && (ph_adj < PHASE_ONE) && (n2 < 6'(ResultCap));
  assign space = (cnt_r != 2'd2);

  // State after a job that gives no interpolated result.
  always_comb begin
    hp_a   = hp_r;
    prev_a = prev_r;
    ph_a   = ph_r;
    if (q_data.frame_done) begin
      prev_a = q_data.cur;
      hp_a   = 1'b1;
      if (hp_r) ph_a = ph_r - PHASE_ONE;
    end
  end

  always_comb begin
    st_nxt   = st_r;
    prev_nxt = prev_r;
    cur_nxt  = cur_r;
    hp_nxt   = hp_r;
    eos_nxt  = eos_r;
    ph_nxt   = ph_r;
    n_nxt    = n_r;
    q_pop    = 1'b0;
    wr       = 1'b0;
    wr_data  = '{mono_sample: y, run_last: 1'b0, stream_last: 1'b0};
    unique case (st_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          cur_nxt = q_data.cur;
          eos_nxt = q_data.eos;
          n_nxt   = '0;
          if (q_data.frame_done && hp_r && (ph_r < PHASE_ONE)) begin
            st_nxt = ST_INTERP;
          end else begin
            prev_nxt = prev_a;
            hp_nxt   = hp_a;
            ph_nxt   = ph_a;
            if (q_data.eos) begin
              if (hp_a && (ph_a < PHASE_ONE)) begin
                st_nxt = ST_TAIL;
              end else begin
                prev_nxt = '0;
                hp_nxt   = 1'b0;
                ph_nxt   = '0;
              end
            end
          end
        end
      end
      ST_INTERP: begin
        if (space) begin
          wr = 1'b1;
          n_nxt = n2;
          if (more) begin
            ph_nxt = ph2;
          end else begin
            wr_data.run_last    = !tail_go;
            wr_data.stream_last = eos_r && !tail_go;
            prev_nxt = cur_r;
            ph_nxt   = ph_adj;
            if (tail_go) begin
              st_nxt = ST_TAIL;
            end else begin
              st_nxt = ST_IDLE;
              if (eos_r) begin
                prev_nxt = '0;
                hp_nxt   = 1'b0;
                ph_nxt   = '0;
              end
            end
          end
        end
      end
      ST_TAIL: begin
        if (space) begin
          wr = 1'b1;
          wr_data.mono_sample = prev_r;
          n_nxt  = n2;
          ph_nxt = ph2;
          if (!more) begin
            wr_data.run_last    = 1'b1;
            wr_data.stream_last = 1'b1;
            st_nxt   = ST_IDLE;
            prev_nxt = '0;
            hp_nxt   = 1'b0;
            ph_nxt   = '0;
          end
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      prev_r <= '0;
      hp_r   <= 1'b0;
      ph_r   <= '0;
      eos_r  <= 1'b0;
      n_r    <= '0;
    end else begin
      st_r   <= st_nxt;
      prev_r <= prev_nxt;
      hp_r   <= hp_nxt;
      ph_r   <= ph_nxt;
      eos_r  <= eos_nxt;
      n_r    <= n_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  assign rd        = out_pop && (cnt_r != 2'd0);
  assign out_empty = (cnt_r == 2'd0);
  assign out_data  = rq_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr) wp_r <= ~wp_r;
      if (rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(wr) - 2'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) rq_r[wp_r] <= wr_data;
  end

endmodule
`default_nettype wire

### rtl/core/pcm_downmix_linear_resampler.sv
// ----------------------------------------------------------------------------
// pcm_downmix_linear_resampler: mono down-mix and linear resampler
// Decodes interleaved PCM16/PCM32/float32 words, averages each frame into one
// mono Q1.23 sample and resamples it by linear interpolation.
// ----------------------------------------------------------------------------
//
//   Channel  Ports                          Beat
//   input    in_push, in_full, in_data      one sample word plus end flag
//   result   out_pop, out_empty, out_data   one mono sample plus run/stream
//   config   cfg_we, cfg_index, cfg_data    one register write, no wait
//
// Only a word that closes a frame holds in_full, through ST_MUL (reciprocal
// multiply) and ST_PUSH (hand-off; waits on a full job queue). The back
// gives one result per cycle while the result queue has room, up to 32 per
// beat, with one interpolation multiplier. Results queue in two entries, so
// the back stalls only when both are held. Reset is synchronous and active
// low; it restores format PCM16, one channel and a unit step.
`default_nettype none
module pcm_downmix_linear_resampler import dmx_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire in_beat_t    in_data,
  input  wire logic        out_pop,
  output logic             out_empty,
  output out_beat_t        out_data,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [19:0] cfg_data
);

  logic [1:0]  fmt_r;
  logic [3:0]  chans_r;
  logic [19:0] step_r;

  // Jobs from the front to the back.
  logic jq_push, jq_full, jq_pop, jq_empty;
  job_t jq_in, jq_out;

  // Register writes; an index past the list is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r   <= FMT_PCM16;
      chans_r <= 4'd1;
      step_r  <= 20'(PHASE_ONE);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FORMAT:   fmt_r   <= cfg_data[1:0];
        REG_CHANNELS: chans_r <= cfg_data[3:0];
        REG_STEP:     step_r  <= cfg_data;
        default:      ;
      endcase
    end
  end

  dmx_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_data       (in_data),
    .sample_format (fmt_r),
    .channel_count (chans_r),
    .q_full        (jq_full),
    .q_push        (jq_push),
    .q_data        (jq_in)
  );

  dmx_jobq u_jobq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (jq_push),
    .push_data (jq_in),
    .full      (jq_full),
    .pop       (jq_pop),
    .empty     (jq_empty),
    .pop_data  (jq_out)
  );

  dmx_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .phase_step (step_r),
    .q_empty    (jq_empty),
    .q_data     (jq_out),
    .q_pop      (jq_pop),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_data   (out_data)
  );

endmodule
`default_nettype wire

### rtl/core/dmx_checker.sv
// ----------------------------------------------------------------------------
// dmx_checker: port-level checks
// Watches the top-level ports over time, bound to the resampler.
// ----------------------------------------------------------------------------
`default_nettype none
module dmx_checker import dmx_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_full,
  input wire logic      out_pop,
  input wire logic      out_empty,
  input wire out_beat_t out_data
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("results present right after reset");

  a_reset_ready: assert property (@(posedge clk) !rst_n |=> !in_full)
    else $error("input blocked right after reset");

  a_stream_run: assert property (@(posedge clk)
    disable iff (!rst_n) (!out_empty && out_data.stream_last) |-> out_data.run_last)
    else $error("stream end beat not closing its run");

  a_hold: assert property (@(posedge clk)
    disable iff (!rst_n) (!out_empty && !out_pop) |=> (!out_empty && $stable(out_data)))
    else $error("waiting result changed");

endmodule

bind pcm_downmix_linear_resampler dmx_checker u_dmx_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_full   (in_full),
  .out_pop   (out_pop),
  .out_empty (out_empty),
  .out_data  (out_data)
);
`default_nettype wire

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for pcm_downmix_linear_resampler
// Drives sample-word beats through the queue-style input and pops mono beats,
// checking each one against a cycle-free model of the decode, down-mix and
// linear interpolation. A directed table comes first, then random streams.
// ----------------------------------------------------------------------------
`default_nettype none
module testbench;
  import dmx_pkg::*;

  // Format code 3 is not assigned; the block decodes every word as zero.
  localparam logic [1:0] FMT_UNUSED = 2'd3;
  localparam int QuietCycles = 64;

  logic        clk;
  logic        rst_n;
  logic        in_push;
  logic        in_full;
  in_beat_t    in_data;
  logic        out_pop;
  logic        out_empty;
  out_beat_t   out_data;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [19:0] cfg_data;

  pcm_downmix_linear_resampler dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_data(in_data),
    .out_pop(out_pop), .out_empty(out_empty), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The run is bounded far above the slowest legal schedule.
  initial begin
    #20000000;
    $display("testbench failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Down-mix and resampler model. It mirrors the register file and the stream
  // state, and appends every mono beat that an accepted word will cause.
  // --------------------------------------------------------------------------
  logic [1:0]  mdl_format;
  logic [3:0]  mdl_channels;
  logic [19:0] mdl_step;
  int unsigned mdl_chan_idx;
  longint      mdl_sum;
  longint      mdl_prev;
  bit          mdl_have_prev;
  longint      mdl_phase;

  out_beat_t   mono_expected[$];
  int          pred_total;
  int          mismatches;
  int          beats_popped;

  function automatic longint clamp_sample(longint v);
    if (v > longint'(SMP_MAX)) return longint'(SMP_MAX);
    if (v < longint'(SMP_MIN)) return longint'(SMP_MIN);
    return v;
  endfunction

  function automatic longint decode_sample(logic [31:0] w);
    logic [7:0]  expo;
    longint      mag;
    int          sh;
    expo = w[30:23];
    case (mdl_format)
      FMT_PCM16: return longint'($signed(w[15:0])) <<< 8;
      FMT_PCM32: return longint'($signed(w)) >>> 8;
      FMT_FLT32: begin
        // NaN is silent, infinity and |x| >= 1 saturate, denormals flush.
        if (expo == 8'hFF && w[22:0] != 0) return 0;
        if (expo == 8'hFF || expo >= 8'd127)
          return w[31] ? longint'(SMP_MIN) : longint'(SMP_MAX);
        if (expo == 8'h00) return 0;
        sh  = 127 - int'(expo);
        mag = (sh >= 40) ? 0 : (longint'({1'b1, w[22:0]}) >> sh);
        return clamp_sample(w[31] ? -mag : mag);
      end
      default: return 0;
    endcase
  endfunction

  function automatic void clear_stream_state();
    mdl_chan_idx  = 0;
    mdl_sum       = 0;
    mdl_prev      = 0;
    mdl_have_prev = 1'b0;
    mdl_phase     = 0;
  endfunction

  function automatic void emit_mono(longint v);
    out_beat_t b;
    b.mono_sample = v[SampleBits-1:0];
    b.run_last    = 1'b0;
    b.stream_last = 1'b0;
    mono_expected.push_back(b);
    pred_total++;
  endfunction

  function automatic void predict_word(logic [31:0] w, logic eos);
    int     chans;
    longint step;
    longint recip;
    longint cur;
    longint frac;
    int     n;
    int     base;
    base  = mono_expected.size();
    n     = 0;
    chans = (mdl_channels == 0) ? 1 : (mdl_channels > MaxChannels) ? MaxChannels
                                                                 : int'(mdl_channels);
    step  = (mdl_step < STEP_MIN) ? longint'(STEP_MIN) :
            (mdl_step > STEP_MAX) ? longint'(STEP_MAX) : longint'(mdl_step);
    mdl_sum += decode_sample(w);
    mdl_chan_idx++;
    if (mdl_chan_idx >= chans) begin
      recip = (65536 + chans / 2) / chans;
      cur   = clamp_sample((mdl_sum * recip) >>> 16);
      mdl_chan_idx = 0;
      mdl_sum      = 0;
      if (!mdl_have_prev) begin
        mdl_have_prev = 1'b1;
      end else begin
        while (mdl_phase < longint'(PHASE_ONE) && n < ResultCap) begin
          frac = mdl_phase & (longint'(PHASE_ONE) - 1);
          emit_mono(mdl_prev + (((cur - mdl_prev) * frac) >>> PhaseFracBits));
          n++;
          mdl_phase += step;
        end
        mdl_phase = (mdl_phase >= longint'(PHASE_ONE)) ? mdl_phase - longint'(PHASE_ONE)
                                                     : 0;
      end
      mdl_prev = cur;
    end
    if (eos) begin
      // The tail repeats the last sample up to the end of its interval.
      if (mdl_have_prev) begin
        while (mdl_phase < longint'(PHASE_ONE) && n < ResultCap) begin
          emit_mono(mdl_prev);
          n++;
          mdl_phase += step;
        end
      end
      clear_stream_state();
      if (n > 0) mono_expected[base + n - 1].stream_last = 1'b1;
    end
    if (n > 0) mono_expected[base + n - 1].run_last = 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Result side: pop with random gaps, plus one long hold that lets the
  // two-entry result queue and the front both fill while words keep coming.
  // --------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  initial begin
    int  g;
    bit  held;
    held    = 1'b0;
    out_pop = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (!held && beats_popped >= 60) begin
        held    = 1'b1;
        out_pop <= 1'b0;
        repeat (400) @(negedge clk);
      end
      g = ($urandom_range(0, 3) == 0) ? 0 : pick_gap();
      if (g > 0) begin
        out_pop <= 1'b0;
        repeat (g) @(negedge clk);
      end
      out_pop <= 1'b1;
    end
  end

  always @(posedge clk) begin
    out_beat_t want;
    if (rst_n && out_pop && !out_empty) begin
      beats_popped++;
      if (mono_expected.size() == 0) begin
        $display("%0t: unexpected beat mono=%0d run_last=%b stream_last=%b", $time,
                 out_data.mono_sample, out_data.run_last, out_data.stream_last);
        mismatches++;
      end else begin
        want = mono_expected.pop_front();
        if (out_data.mono_sample !== want.mono_sample) begin
          $display("%0t: mono_sample expected %0d got %0d", $time,
                   want.mono_sample, out_data.mono_sample);
          mismatches++;
        end
        if (out_data.run_last !== want.run_last) begin
          $display("%0t: run_last expected %b got %b", $time,
                   want.run_last, out_data.run_last);
          mismatches++;
        end
        if (out_data.stream_last !== want.stream_last) begin
          $display("%0t: stream_last expected %b got %b", $time,
                   want.stream_last, out_data.stream_last);
          mismatches++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input side. Every task starts and ends on a falling edge.
  // --------------------------------------------------------------------------
  task automatic push_word(input logic [31:0] w, input logic eos, input bit gaps);
    int g;
    in_data.sample_word   <= w;
    in_data.end_of_stream <= eos;
    in_push               <= 1'b1;
    do @(posedge clk); while (in_full);
    predict_word(w, eos);
    @(negedge clk);
    g = gaps ? pick_gap() : 0;
    if (g > 0) begin
      in_push <= 1'b0;
      repeat (g) @(negedge clk);
    end
  endtask

  // Registers change only with nothing in flight; words that finish no
  // result may still be in the front when the last beat is popped.
  task automatic drain_block();
    in_push <= 1'b0;
    wait (mono_expected.size() == 0);
    @(negedge clk);
    repeat (QuietCycles) @(negedge clk);
  endtask

  task automatic write_regs(input logic [1:0] fmt, input logic [3:0] ch,
                            input logic [19:0] stp);
    cfg_we    <= 1'b1;
    cfg_index <= REG_FORMAT;
    cfg_data  <= 20'(fmt);
    @(negedge clk);
    cfg_index <= REG_CHANNELS;
    cfg_data  <= 20'(ch);
    @(negedge clk);
    cfg_index <= REG_STEP;
    cfg_data  <= stp;
    @(negedge clk);
    cfg_we <= 1'b0;
    mdl_format   = fmt;
    mdl_channels = ch;
    mdl_step     = stp;
  endtask

  function automatic logic [31:0] random_word(logic [1:0] fmt);
    logic [31:0] w;
    w = $urandom;
    // Most float words fall inside (-1, 1) so the mantissa path is busy.
    if (fmt == FMT_FLT32 && $urandom_range(0, 3) != 0)
      w[30:23] = 8'($urandom_range(100, 127));
    return w;
  endfunction

  typedef struct {
    logic [1:0]  fmt;
    logic [3:0]  ch;
    logic [19:0] stp;
    logic [31:0] word;
    logic        eos;
    bit          chk;
    logic signed [SampleBits-1:0] first;
  } stim_row_t;

  // Directed rows. Where chk is set, the first beat that the row causes is
  // known by hand and is checked against the model before it goes out.
  stim_row_t directed[] = '{
    // Reset setting: PCM16, mono, unit step. Full scale both ways, then tail.
    '{FMT_PCM16, 4'd1, 20'd65536, 32'h0000_7FFF, 1'b0, 1'b0, 24'sd0},
    '{FMT_PCM16, 4'd1, 20'd65536, 32'hFFFF_8000, 1'b0, 1'b1, 24'sh7FFF00},
    '{FMT_PCM16, 4'd1, 20'd65536, 32'h0000_0000, 1'b1, 1'b1, 24'sh800000},
    // A stream of a single frame: only its tail comes out.
    '{FMT_PCM16, 4'd1, 20'd65536, 32'h1234_5678, 1'b1, 1'b0, 24'sd0},
    // PCM32 at the finest step: sixteen beats per sample.
    '{FMT_PCM32, 4'd1, 20'd4096,  32'h7FFF_FFFF, 1'b0, 1'b0, 24'sd0},
    '{FMT_PCM32, 4'd1, 20'd4096,  32'h8000_0000, 1'b0, 1'b1, 24'sh7FFFFF},
    '{FMT_PCM32, 4'd1, 20'd4096,  32'hFFFF_FFFF, 1'b1, 1'b1, 24'sh800000},
    // Float: saturation, infinity, NaN, negative zero, denormal, in range.
    '{FMT_FLT32, 4'd1, 20'd0,     32'h3F80_0000, 1'b0, 1'b0, 24'sd0},
    '{FMT_FLT32, 4'd1, 20'd0,     32'hBF80_0000, 1'b0, 1'b1, 24'sh7FFFFF},
    '{FMT_FLT32, 4'd1, 20'd0,     32'h7F80_0000, 1'b0, 1'b1, 24'sh800000},
    '{FMT_FLT32, 4'd1, 20'd0,     32'h7FC0_0000, 1'b0, 1'b0, 24'sd0},
    '{FMT_FLT32, 4'd1, 20'd0,     32'hFF80_0000, 1'b0, 1'b0, 24'sd0},
    '{FMT_FLT32, 4'd1, 20'd0,     32'h8000_0000, 1'b0, 1'b0, 24'sd0},
    '{FMT_FLT32, 4'd1, 20'd0,     32'h0000_0001, 1'b0, 1'b0, 24'sd0},
    '{FMT_FLT32, 4'd1, 20'd0,     32'h3F00_0000, 1'b1, 1'b0, 24'sd0},
    // Six channels of full-scale negative: the rounded-up reciprocal clips.
    '{FMT_PCM16, 4'd6, 20'd786432, 32'h0000_8000, 1'b0, 1'b0, 24'sd0},
    '{FMT_PCM16, 4'd6, 20'd786432, 32'h0000_8000, 1'b0, 1'b0, 24'sd0},
    '{FMT_PCM16, 4'd6, 20'd786432, 32'h0000_8000, 1'b0, 1'b0, 24'sd0},
    '{FMT_PCM16, 4'd6, 20'd786432, 32'h0000_8000, 1'b0, 1'b0, 24'sd0},
    '{FMT_PCM16, 4'd6, 20'd786432, 32'h0000_8000, 1'b0, 1'b0, 24'sd0},
    '{FMT_PCM16, 4'd6, 20'd786432, 32'h0000_8000, 1'b1, 1'b1, 24'sh800000},
    // Zero channels acts as one, step above the range clamps to twelve.
    '{FMT_PCM32, 4'd0, 20'hFFFFF, 32'h4000_0000, 1'b0, 1'b0, 24'sd0},
    '{FMT_PCM32, 4'd0, 20'hFFFFF, 32'hC000_0000, 1'b0, 1'b0, 24'sd0},
    // Unused format, and a channel count past the maximum with a partial
    // trailing frame that is dropped.
    '{FMT_UNUSED, 4'd15, 20'd65536, 32'hDEAD_BEEF, 1'b0, 1'b0, 24'sd0},
    '{FMT_UNUSED, 4'd15, 20'd65536, 32'h2152_4110, 1'b1, 1'b0, 24'sd0}
  };

  initial begin
    int          sent;
    int          base;
    int          idx;
    int          len;
    logic [1:0]  fmt;
    logic [3:0]  ch;
    logic [19:0] stp;

    in_push   = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = REG_FORMAT;
    cfg_data  = '0;
    rst_n     = 1'b0;
    mismatches   = 0;
    beats_popped = 0;
    pred_total   = 0;
    mdl_format   = FMT_PCM16;
    mdl_channels = 4'd1;
    mdl_step     = 20'd65536;
    clear_stream_state();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table. The first rows run on the reset values.
    foreach (directed[i]) begin
      if (directed[i].fmt != mdl_format || directed[i].ch != mdl_channels ||
          directed[i].stp != mdl_step) begin
        drain_block();
        write_regs(directed[i].fmt, directed[i].ch, directed[i].stp);
      end
      // Older beats may be popped while the word waits, so the row's first
      // beat is located by its running number rather than a queue position.
      base = pred_total;
      push_word(directed[i].word, directed[i].eos, 1'b0);
      idx = base - (pred_total - mono_expected.size());
      if (directed[i].chk && (pred_total <= base || idx < 0 ||
          mono_expected[idx].mono_sample !== directed[i].first)) begin
        $display("%0t: row %0d expected first beat %0d", $time, i, directed[i].first);
        mismatches++;
      end
    end

    // Random phases: a fresh setting each time, mostly well-formed streams.
    sent = 0;
    while (sent < 320) begin
      drain_block();
      fmt = ($urandom_range(0, 9) == 0) ? FMT_UNUSED : 2'($urandom_range(0, 2));
      ch  = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                        : 4'($urandom_range(1, 8));
      case ($urandom_range(0, 5))
        0:       stp = STEP_MIN;
        1:       stp = STEP_MAX;
        2:       stp = 20'($urandom);
        default: stp = 20'($urandom_range(16384, 196608));
      endcase
      write_regs(fmt, ch, stp);
      repeat ($urandom_range(1, 3)) begin
        len = $urandom_range(1, 12) * ((ch == 0) ? 1 : int'(ch));
        if ($urandom_range(0, 4) == 0) len += $urandom_range(0, 3);
        for (int k = 0; k < len; k++) begin
          push_word(random_word(fmt),
                    (k == len - 1) && ($urandom_range(0, 9) != 0), 1'b1);
          sent++;
        end
      end
    end

    // Close any open stream, then let everything drain out.
    push_word(random_word(mdl_format), 1'b1, 1'b0);
    drain_block();

    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
